[rtl/bcpe_pkg.sv]
// Package for the Bezier curve point evaluator.
// Holds the shared widths, types and defaults; no dependencies.
`default_nettype none
package bcpe_pkg;
  localparam int unsigned MaxPointsDefault = 8;
  localparam int unsigned CoordW = 32;
  localparam int unsigned TW = 17;
  localparam int unsigned CountW = 4;
  localparam int unsigned IndexW = 3;
  localparam logic [TW-1:0] TOne = 17'd65536;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Control from the sequencer to every cell of the row.
  typedef struct packed {
    logic load;
    logic step;
  } cell_ctl_t;
endpackage
`default_nettype wire

[rtl/bcpe_if.sv]
// Valid/ready channel interfaces for request and result beats.
// Depends on bcpe_pkg.
`default_nettype none
interface bcpe_req_if;
  logic valid;
  logic ready;
  logic kind;
  logic [bcpe_pkg::IndexW-1:0] point_index;
  logic signed [bcpe_pkg::CoordW-1:0] point_x;
  logic signed [bcpe_pkg::CoordW-1:0] point_y;
  logic [bcpe_pkg::TW-1:0] param_t;
  modport source (output valid, kind, point_index, point_x, point_y, param_t, input ready);
  modport sink (input valid, kind, point_index, point_x, point_y, param_t, output ready);
endinterface

interface bcpe_rsp_if;
  logic valid;
  logic ready;
  logic signed [bcpe_pkg::CoordW-1:0] curve_x;
  logic signed [bcpe_pkg::CoordW-1:0] curve_y;
  modport source (output valid, curve_x, curve_y, input ready);
  modport sink (input valid, curve_x, curve_y, output ready);
endinterface
`default_nettype wire

[rtl/bezier_curve_point_eval.sv]
// Bezier curve point evaluator: point table, sequencer and a row of cells.
// Depends on bcpe_pkg, bcpe_if and bcpe_cell.
//
// Use: request beats arrive on req. A beat of kind load writes one control
// point (point_x, point_y) at point_index and gives no result; an index not
// below MAX_POINTS is dropped. A beat of kind evaluate gives one result beat
// on rsp holding B(param_t) over the first point_count points (the count
// clamped into 2..MAX_POINTS), t clamped to 1.0. The count register is
// written through cfg_we/cfg_data; the user must write it only while idle,
// and the block itself does not enforce this. An evaluation copies the table
// into a row of MAX_POINTS cells, then runs point_count-1 interpolation
// rounds, one per cycle, every cell blending with its right-hand neighbour;
// cell 0 then holds the result, which moves to the output register once that
// register is free. The block takes one request at a time; a new request is
// accepted as soon as the result sits in the output register, even if the
// receiver has not yet taken it. If the receiver stalls, the finished result
// waits in the cells and no further request is taken until it can move.
// Reset clears the sequencer, the output valid and sets point_count to 2;
// the point table is not cleared and must be loaded before use.
`default_nettype none
module bezier_curve_point_eval #(
  parameter int unsigned MAX_POINTS = bcpe_pkg::MaxPointsDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  bcpe_req_if.sink                         req,
  bcpe_rsp_if.source                       rsp,
  input  wire logic                        cfg_we,
  input  wire logic [bcpe_pkg::CountW-1:0] cfg_data
);
  localparam int unsigned RW = $clog2(MAX_POINTS);

  bcpe_pkg::state_t state, state_next;
  logic [bcpe_pkg::CountW-1:0] point_count;
  logic [RW-1:0] left;
  logic [bcpe_pkg::TW-1:0] t_reg;
  bcpe_pkg::coord_t tab_x [MAX_POINTS];
  bcpe_pkg::coord_t tab_y [MAX_POINTS];
  bcpe_pkg::coord_t cx [MAX_POINTS];
  bcpe_pkg::coord_t cy [MAX_POINTS];
  logic out_valid;
  bcpe_pkg::coord_t out_x, out_y;
  bcpe_pkg::cell_ctl_t ctl;
  logic acc, eval_acc, out_free, out_load;
  logic [bcpe_pkg::CountW-1:0] n_used;

  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == bcpe_pkg::ST_IDLE);
  assign acc = req.valid && req.ready;
  assign eval_acc = acc && (req.kind == bcpe_pkg::KIND_EVAL);

  // Count clamped into 2..MAX_POINTS.
  always_comb begin
    if (point_count < 4'd2) begin
      n_used = 4'd2;
    end else if (32'(point_count) > MAX_POINTS) begin
      n_used = bcpe_pkg::CountW'(MAX_POINTS);
    end else begin
      n_used = point_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 4'd2;
    end else if (cfg_we) begin
      point_count <= cfg_data;
    end
  end

  // Point table: each entry feeds its own cell, so it stays in flip-flops.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (acc && req.kind == bcpe_pkg::KIND_LOAD && 32'(req.point_index) == i) begin
        tab_x[i] <= req.point_x;
        tab_y[i] <= req.point_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval_acc) begin
      t_reg <= (req.param_t > bcpe_pkg::TOne) ? bcpe_pkg::TOne : req.param_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcpe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.load = 1'b0;
    ctl.step = 1'b0;
    out_load = 1'b0;
    unique case (state)
      bcpe_pkg::ST_IDLE: begin
        if (eval_acc) begin
          ctl.load = 1'b1;
          state_next = bcpe_pkg::ST_RUN;
        end
      end
      bcpe_pkg::ST_RUN: begin
        ctl.step = 1'b1;
        if (left == RW'(1)) begin
          state_next = bcpe_pkg::ST_DONE;
        end
      end
      bcpe_pkg::ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_next = bcpe_pkg::ST_IDLE;
        end
      end
      default: state_next = bcpe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      left <= RW'(n_used - 4'd1);
    end else if (ctl.step) begin
      left <= left - RW'(1);
    end
  end

  // The row of cells; the last one blends with itself, which only affects
  // cells whose values never reach cell 0 in the rounds that are run.
  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    localparam int unsigned Nb = (g + 1 < MAX_POINTS) ? g + 1 : g;
    bcpe_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .load_x (tab_x[g]),
      .load_y (tab_y[g]),
      .nb_x   (cx[Nb]),
      .nb_y   (cy[Nb]),
      .t      (t_reg),
      .x      (cx[g]),
      .y      (cy[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x <= cx[0];
      out_y <= cy[0];
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.curve_x = out_x;
  assign rsp.curve_y = out_y;

`ifndef SYNTHESIS
  a_run_left: assert property (@(posedge clk) disable iff (rst)
    state == bcpe_pkg::ST_RUN |-> left != '0)
    else $error("round counter empty while running");
  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == bcpe_pkg::ST_DONE))
    else $error("result appeared without a finished evaluation");
  a_eval_starts_run: assert property (@(posedge clk) disable iff (rst)
    eval_acc |=> state == bcpe_pkg::ST_RUN)
    else $error("evaluation did not start");
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && state == bcpe_pkg::ST_IDLE)
    else $error("reset did not clear control");
`endif
endmodule
`default_nettype wire

[rtl/bcpe_cell.sv]
// One de Casteljau cell: holds one point and interpolates towards its neighbour.
// Depends on bcpe_pkg.
`default_nettype none
module bcpe_cell (
  input  wire logic                  clk,
  input  wire bcpe_pkg::cell_ctl_t   ctl,
  input  wire bcpe_pkg::coord_t      load_x,
  input  wire bcpe_pkg::coord_t      load_y,
  input  wire bcpe_pkg::coord_t      nb_x,
  input  wire bcpe_pkg::coord_t      nb_y,
  input  wire logic [bcpe_pkg::TW-1:0] t,
  output bcpe_pkg::coord_t           x,
  output bcpe_pkg::coord_t           y
);
  // a + t*(b-a), rounded half up to Q16.16.
  function automatic bcpe_pkg::coord_t lerp(input bcpe_pkg::coord_t a,
                                            input bcpe_pkg::coord_t b,
                                            input logic [bcpe_pkg::TW-1:0] w);
    logic signed [32:0] diff;
    logic signed [50:0] prod;
    logic signed [50:0] sum;
    diff = 33'(signed'({b[31], b})) - 33'(signed'({a[31], a}));
    prod = 51'(signed'({1'b0, w})) * 51'(diff);
    sum = prod + 51'(signed'({{3{a[31]}}, a, 16'b0})) + 51'sd32768;
    return sum[47:16];
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= load_x;
      y <= load_y;
    end else if (ctl.step) begin
      x <= lerp(x, nb_x, t);
      y <= lerp(y, nb_y, t);
    end
  end
endmodule
`default_nettype wire

[verif/bezier_curve_point_eval_tb.sv]
// Self-checking bench for the Bezier curve point evaluator.
// Depends on bcpe_pkg, bcpe_if and the bezier_curve_point_eval RTL.
`default_nettype none
module bezier_curve_point_eval_tb;

  localparam int unsigned NPTS = 8;
  localparam int unsigned RAND_BEATS = 1800;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [bcpe_pkg::CountW-1:0] cfg_data = '0;

  bcpe_req_if req ();
  bcpe_rsp_if rsp ();

  bezier_curve_point_eval #(.MAX_POINTS(NPTS)) uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // One expected curve point per evaluate beat, oldest first.
  typedef struct packed {
    bcpe_pkg::coord_t x;
    bcpe_pkg::coord_t y;
  } curve_pt_t;

  // One row of the directed table. When has_want is set the expected
  // point is typed in and must also agree with the predictor.
  typedef struct packed {
    bcpe_pkg::kind_t             kind;
    logic [bcpe_pkg::IndexW-1:0] idx;
    bcpe_pkg::coord_t            px;
    bcpe_pkg::coord_t            py;
    logic [bcpe_pkg::TW-1:0]     t;
    logic                        has_want;
    bcpe_pkg::coord_t            wx;
    bcpe_pkg::coord_t            wy;
  } dir_row_t;

  curve_pt_t pending_pts[$];
  bcpe_pkg::coord_t table_x[NPTS];
  bcpe_pkg::coord_t table_y[NPTS];
  logic [bcpe_pkg::CountW-1:0] count_reg;
  int  n_errors = 0;
  bit  hold_off = 1'b0;
  bit  rand_rsp_stall = 1'b1;
  longint unsigned cycle_no = 0;

  // One rounded interpolation step, worked in offset binary so that the
  // arithmetic stays unsigned; the block itself works in signed arithmetic.
  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b,
                                        logic [16:0] t);
    logic [63:0] acc;
    acc = 64'(17'd65536 - t) * 64'(a) + 64'(t) * 64'(b) + 64'd32768;
    return acc[47:16];
  endfunction

  // De Casteljau over the table with the current count; t is clamped.
  function automatic curve_pt_t bezier_point(logic [bcpe_pkg::TW-1:0] t_in);
    logic [31:0] vx[NPTS];
    logic [31:0] vy[NPTS];
    int n;
    logic [16:0] t;
    curve_pt_t p;
    n = int'(count_reg);
    if (n < 2) n = 2;
    if (n > NPTS) n = NPTS;
    t = (t_in > bcpe_pkg::TOne) ? bcpe_pkg::TOne : t_in;
    for (int i = 0; i < NPTS; i++) begin
      vx[i] = table_x[i] ^ 32'h8000_0000;
      vy[i] = table_y[i] ^ 32'h8000_0000;
    end
    for (int r = 1; r < n; r++) begin
      for (int i = 0; i + r < n; i++) begin
        vx[i] = blend(vx[i], vx[i+1], t);
        vy[i] = blend(vy[i], vy[i+1], t);
      end
    end
    p.x = vx[0] ^ 32'h8000_0000;
    p.y = vy[0] ^ 32'h8000_0000;
    return p;
  endfunction

  // Random idle gap: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic tick(int n);
    repeat (n) @(posedge clk);
  endtask

  // Offer one beat and wait for it to be taken. The predictor is updated
  // at acceptance, so the expected queue always matches beat order.
  task automatic send_beat(bcpe_pkg::kind_t k, logic [bcpe_pkg::IndexW-1:0] idx,
                           bcpe_pkg::coord_t px, bcpe_pkg::coord_t py,
                           logic [bcpe_pkg::TW-1:0] t, bit keep_valid);
    req.valid <= 1'b1;
    req.kind <= k;
    req.point_index <= idx;
    req.point_x <= px;
    req.point_y <= py;
    req.param_t <= t;
    do @(posedge clk); while (!req.ready);
    if (k == bcpe_pkg::KIND_LOAD) begin
      table_x[idx] = px;
      table_y[idx] = py;
    end else begin
      pending_pts.push_back(bezier_point(t));
    end
    if (!keep_valid) req.valid <= 1'b0;
  endtask

  task automatic send_gapped(bcpe_pkg::kind_t k, logic [bcpe_pkg::IndexW-1:0] idx,
                             bcpe_pkg::coord_t px, bcpe_pkg::coord_t py,
                             logic [bcpe_pkg::TW-1:0] t);
    int g;
    g = gap_len();
    send_beat(k, idx, px, py, t, g == 0);
    if (g != 0) tick(g);
  endtask

  // Stops offering, drains all results, then lets the block settle before
  // a register write.
  task automatic wait_idle();
    req.valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    tick(NPTS + 4);
  endtask

  task automatic write_count(logic [bcpe_pkg::CountW-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    count_reg = v;
  endtask

  function automatic bcpe_pkg::coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return bcpe_pkg::coord_t'($urandom_range(0, 65535)) - 32'sd32768;
      default: return bcpe_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [bcpe_pkg::TW-1:0] rand_t();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return bcpe_pkg::TOne;
      2: return bcpe_pkg::TW'($urandom_range(65537, 131071));
      default: return bcpe_pkg::TW'($urandom_range(0, 65536));
    endcase
  endfunction

  // Result checker: every accepted result beat is compared with the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_pts.size() == 0) begin
        $error("unexpected result beat x=%0d y=%0d", rsp.curve_x, rsp.curve_y);
        n_errors++;
      end else begin
        curve_pt_t w;
        w = pending_pts.pop_front();
        if (rsp.curve_x !== w.x) begin
          $error("curve_x expected %0d actual %0d", w.x, rsp.curve_x);
          n_errors++;
        end
        if (rsp.curve_y !== w.y) begin
          $error("curve_y expected %0d actual %0d", w.y, rsp.curve_y);
          n_errors++;
        end
      end
    end
  end

  // Receiver side: random stalls, always ready when stalls are off, or a long hold-off when asked for.
  initial begin
    int g;
    rsp.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        rsp.ready <= 1'b0;
        @(posedge clk);
      end else if (!rand_rsp_stall) begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end else begin
        g = gap_len();
        if (g == 0) begin
          rsp.ready <= 1'b1;
          @(posedge clk);
        end else begin
          rsp.ready <= 1'b0;
          tick(g);
        end
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("bezier_curve_point_eval_tb: errors");
      $finish;
    end
  end

  // Directed table: loads cover the coordinate extremes and the dropped
  // index is out of reach with eight entries. With two equal end points
  // the curve is that point whatever t; t at zero gives the first point,
  // t at one (or clamped above one) gives the last.
  dir_row_t dir_rows[] = '{
    '{bcpe_pkg::KIND_LOAD, 3'd0, 32'sh0001_0000, 32'sh0002_0000, '0, 1'b0, '0, '0},
    '{bcpe_pkg::KIND_LOAD, 3'd1, 32'sh0003_0000, -32'sh0004_0000, 17'h1FFFF, 1'b0,
      '0, '0},
    '{bcpe_pkg::KIND_EVAL, 3'd7, 32'sh1234, 32'sh5678, 17'd0, 1'b1,
      32'sh0001_0000, 32'sh0002_0000},
    '{bcpe_pkg::KIND_EVAL, 3'd0, '0, '0, 17'd65536, 1'b1,
      32'sh0003_0000, -32'sh0004_0000},
    '{bcpe_pkg::KIND_EVAL, 3'd0, '0, '0, 17'h1FFFF, 1'b1,
      32'sh0003_0000, -32'sh0004_0000},
    '{bcpe_pkg::KIND_EVAL, 3'd0, '0, '0, 17'd32768, 1'b1,
      32'sh0002_0000, -32'sh0001_0000},
    '{bcpe_pkg::KIND_LOAD, 3'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, '0, 1'b0, '0, '0},
    '{bcpe_pkg::KIND_LOAD, 3'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, '0, 1'b0, '0, '0},
    '{bcpe_pkg::KIND_EVAL, 3'd0, '0, '0, 17'd12345, 1'b1,
      32'sh7FFF_FFFF, 32'sh8000_0000},
    '{bcpe_pkg::KIND_LOAD, 3'd1, 32'sh8000_0000, 32'sh7FFF_FFFF, '0, 1'b0, '0, '0},
    '{bcpe_pkg::KIND_EVAL, 3'd0, '0, '0, 17'd32768, 1'b0, '0, '0},
    '{bcpe_pkg::KIND_EVAL, 3'd0, '0, '0, 17'd1, 1'b0, '0, '0},
    '{bcpe_pkg::KIND_EVAL, 3'd0, '0, '0, 17'd65535, 1'b0, '0, '0},
    '{bcpe_pkg::KIND_LOAD, 3'd2, 32'sh0000_8000, -32'sh0000_8000, '0, 1'b0, '0, '0},
    '{bcpe_pkg::KIND_LOAD, 3'd3, -32'sh1, 32'sh1, '0, 1'b0, '0, '0},
    '{bcpe_pkg::KIND_LOAD, 3'd4, 32'sh5555_5555, 32'shAAAA_AAAA, '0, 1'b0, '0, '0},
    '{bcpe_pkg::KIND_LOAD, 3'd5, 32'shAAAA_AAAA, 32'sh5555_5555, '0, 1'b0, '0, '0},
    '{bcpe_pkg::KIND_LOAD, 3'd6, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, '0, 1'b0, '0, '0},
    '{bcpe_pkg::KIND_LOAD, 3'd7, 32'shF0F0_F0F0, 32'sh0F0F_0F0F, '0, 1'b0, '0, '0}
  };

  // Register settings walked by the random part, extremes and the
  // out-of-range counts included.
  logic [bcpe_pkg::CountW-1:0] count_plan[] = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd5, 4'd1,
                                                4'd3, 4'd9, 4'd7, 4'd4, 4'd6, 4'd8};

  initial begin
    int per_phase;
    req.valid = 1'b0;
    req.kind = bcpe_pkg::KIND_LOAD;
    req.point_index = '0;
    req.point_x = '0;
    req.point_y = '0;
    req.param_t = '0;
    count_reg = 4'd2;
    tick(2);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset count of two, then six evaluations at a count of eight.
    foreach (dir_rows[i]) begin
      dir_row_t d;
      d = dir_rows[i];
      if (d.kind == bcpe_pkg::KIND_EVAL && d.has_want) begin
        curve_pt_t p;
        p = bezier_point(d.t);
        if (p.x !== d.wx || p.y !== d.wy) begin
          $error("table row %0d: predictor x=%0d y=%0d typed x=%0d y=%0d",
                 i, p.x, p.y, d.wx, d.wy);
          n_errors++;
        end
      end
      send_gapped(d.kind, d.idx, d.px, d.py, d.t);
    end
    wait_idle();
    write_count(4'd8);
    for (int i = 0; i < 6; i++)
      send_gapped(bcpe_pkg::KIND_EVAL, 3'($urandom), rand_coord(), rand_coord(),
                  rand_t());

    // Random part: the directed part has written every table entry, so no
    // entry is read unwritten; loads and evaluations are mixed.
    per_phase = RAND_BEATS / count_plan.size();
    foreach (count_plan[p]) begin
      wait_idle();
      write_count(count_plan[p]);
      rand_rsp_stall = (p % 4) != 3;
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 99) < 35)
          send_gapped(bcpe_pkg::KIND_LOAD, 3'($urandom), rand_coord(), rand_coord(),
                      bcpe_pkg::TW'($urandom));
        else
          send_gapped(bcpe_pkg::KIND_EVAL, 3'($urandom), rand_coord(), rand_coord(),
                      rand_t());
        // Half way through one phase the receiver holds off for a long
        // stretch while evaluations keep being offered back to back.
        if (p == 4 && i == per_phase / 2) begin
          fork
            begin
              hold_off = 1'b1;
              tick(300);
              hold_off = 1'b0;
            end
          join_none
          for (int j = 0; j < 6; j++)
            send_beat(bcpe_pkg::KIND_EVAL, '0, '0, '0, rand_t(), 1'b1);
        end
      end
    end
    rand_rsp_stall = 1'b1;

    req.valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    tick(NPTS + 8);
    if (n_errors == 0) begin
      $display("bezier_curve_point_eval_tb: clean");
    end else begin
      $display("bezier_curve_point_eval_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
